// ===== src/salru_pkg.sv =====
// Shared types and constants for the per-set LRU list engine.
package salru_pkg;

   localparam int unsigned WAYS       = 16;
   localparam int unsigned SETS       = 1024;
   localparam int unsigned WAY_W      = $clog2(WAYS);
   localparam int unsigned LINK_W     = WAY_W + 1;
   localparam int unsigned SET_W      = $clog2(SETS);
   localparam int unsigned BLK_W      = SET_W + WAY_W;
   localparam int unsigned STEP_W     = $clog2(WAYS + 1);
   localparam int unsigned MASK_W     = 16;
   localparam int unsigned CNT_W      = 5;
   localparam int unsigned KIND_W     = 3;
   localparam int unsigned CLR_W      = BLK_W;

   typedef logic [LINK_W-1:0] link_type;
   localparam link_type NIL = {LINK_W{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      KIND_HIT    = 3'd0,
      KIND_FILL   = 3'd1,
      KIND_DELETE = 3'd2,
      KIND_VICTIM = 3'd3,
      KIND_FLUSH  = 3'd4
   } kind_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_SET,
      ST_RD_BLK,
      ST_HIT_CHK,
      ST_UNLINK,
      ST_UNLINK_OWN,
      ST_APPEND_RD,
      ST_APPEND,
      ST_WALK_RD,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic found;
      logic [BLK_W-1:0] index;
      logic [MASK_W-1:0] fmask;
      logic [CNT_W-1:0] fcount;
   } result_type;

   // every link value below NIL is a way only if it is below WAYS
   function automatic link_type clean_link(input link_type v);
      clean_link = (v < link_type'(WAYS)) ? v : NIL;
   endfunction

endpackage

// ===== src/salru_outbuf.sv =====
// Output register holding one result word until the receiver takes it.
module salru_outbuf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  salru_pkg::result_type  data,
   output logic                   busy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output salru_pkg::result_type  q
);
   logic                  valid_ff, valid_in;
   salru_pkg::result_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      if (load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (load) data_ff <= data;
   end

   assign rsp_valid = valid_ff;
   assign busy      = valid_ff && rsp_stall;
   assign q         = data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !(valid_ff && rsp_stall)) else $error("result overwritten");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall && !load) |=> (valid_ff && $stable(data_ff)))
      else $error("result lost");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_stall && !load) |=> !valid_ff) else $error("result repeated");
endmodule

// ===== src/set_assoc_lru_list_engine.sv =====
// Top level: per-set doubly linked LRU lists walked by a small sequencer.
//
// Requests arrive on req_* (valid/stall), one word at a time; the engine
// stalls the request channel while it works on a word and while it clears.
// Each accepted request gives exactly one response word on rsp_*.
// Hit, fill and delete are read-modify-write sequences over the head/tail
// and prev/next memories. Find victim and flush set walk the next links
// from the head, each link by its address and then its registered read data
// (ST_WALK_RD, then ST_WALK) through the single next-link memory read port,
// visiting at most WAYS links. The response is valid the cycle after the
// last sequencer step and then sits in an output register; the next request
// is taken while it waits, but a second response is not produced until the
// first has been taken. After reset a clearing pass writes null into every
// link memory entry, one block (and one set) a cycle; no request is accepted
// during it. Out-of-range indices and unused kinds give an all-zero response.
module set_assoc_lru_list_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [13:0] req_block_index,
   input  logic [9:0]  req_set_index,
   input  logic [15:0] req_idle_valid_mask,
   input  logic [15:0] req_dirty_mask,
   input  logic [15:0] req_busy_mask,
   input  logic [4:0]  req_flush_limit,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_victim_found,
   output logic [13:0] rsp_victim_index,
   output logic [15:0] rsp_flush_mask,
   output logic [4:0]  rsp_flushed_count
);
   localparam int unsigned BW = salru_pkg::BLK_W;
   localparam int unsigned SW = salru_pkg::SET_W;
   localparam int unsigned WW = salru_pkg::WAY_W;
   localparam int unsigned LW = salru_pkg::LINK_W;

   typedef logic [LW-1:0] lk_type;

   // memories
   lk_type head_mem [salru_pkg::SETS];
   lk_type tail_mem [salru_pkg::SETS];
   lk_type prev_mem [salru_pkg::SETS * salru_pkg::WAYS];
   lk_type next_mem [salru_pkg::SETS * salru_pkg::WAYS];

   salru_pkg::state_type state_ff, state_in;
   logic [2:0]        kind_ff;
   logic [SW-1:0]     set_ff;
   logic [WW-1:0]     way_ff;
   logic [15:0]       ivm_ff, dm_ff, busy_ff, busy_in;
   logic [4:0]        limit_ff;
   logic              hit_ff, hit_in;      // set for a hit request, which appends after its unlink
   logic [BW:0]       clr_ff, clr_in;
   lk_type            p_ff, p_in, n_ff, n_in, h_ff, h_in, t_ff, t_in;
   lk_type            w_ff, w_in;
   logic [salru_pkg::STEP_W-1:0] steps_ff, steps_in;
   salru_pkg::result_type res_ff, res_in;
   logic              ob_busy, load;
   salru_pkg::result_type ob_q;

   // memory read data
   lk_type head_rd, tail_rd, prev_rd, next_rd;
   logic [SW-1:0] set_raddr;
   logic [BW-1:0] blk_raddr;

   // write ports (one each)
   logic          hw_en, tw_en, pw_en, nw_en;
   logic [SW-1:0] hw_a, tw_a;
   logic [BW-1:0] pw_a, nw_a;
   lk_type        hw_d, tw_d, pw_d, nw_d;

   logic accept, blk_ok, set_ok;
   logic [BW-1:0] blk_self;

   // append uses the link state captured in the read step, or fresh reads after unlink
   lk_type append_t, append_h;

   assign req_stall = (state_ff != salru_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign blk_self  = {set_ff, way_ff};
   assign blk_ok    = ({1'b0, req_block_index} < 15'(salru_pkg::SETS * salru_pkg::WAYS));
   assign set_ok    = ({1'b0, req_set_index} < 11'(salru_pkg::SETS));
   assign append_t  = (kind_ff == salru_pkg::KIND_HIT) ? salru_pkg::clean_link(tail_rd) : t_ff;
   assign append_h  = (kind_ff == salru_pkg::KIND_HIT) ? salru_pkg::clean_link(head_rd) : h_ff;

   always_ff @(posedge clock) begin
      head_rd <= head_mem[set_raddr];
      tail_rd <= tail_mem[set_raddr];
      prev_rd <= prev_mem[blk_raddr];
      next_rd <= next_mem[blk_raddr];
      if (hw_en) head_mem[hw_a] <= hw_d;
      if (tw_en) tail_mem[tw_a] <= tw_d;
      if (pw_en) prev_mem[pw_a] <= pw_d;
      if (nw_en) next_mem[nw_a] <= nw_d;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         salru_pkg::ST_CLEAR:
            if (clr_ff[BW]) state_in = salru_pkg::ST_IDLE;
         salru_pkg::ST_IDLE:
            if (accept) begin
               if ((req_kind == salru_pkg::KIND_HIT || req_kind == salru_pkg::KIND_FILL
                    || req_kind == salru_pkg::KIND_DELETE) && blk_ok)
                  state_in = salru_pkg::ST_RD_SET;
               else if ((req_kind == salru_pkg::KIND_VICTIM
                         || req_kind == salru_pkg::KIND_FLUSH) && set_ok)
                  state_in = salru_pkg::ST_RD_SET;
               else
                  state_in = salru_pkg::ST_DONE;
            end
         salru_pkg::ST_RD_SET: state_in = salru_pkg::ST_RD_BLK;
         salru_pkg::ST_RD_BLK:
            case (kind_ff)
               salru_pkg::KIND_HIT:    state_in = salru_pkg::ST_HIT_CHK;
               salru_pkg::KIND_FILL:   state_in = salru_pkg::ST_APPEND_RD;
               salru_pkg::KIND_DELETE: state_in = salru_pkg::ST_UNLINK;
               default:                state_in = salru_pkg::ST_WALK_RD;
            endcase
         salru_pkg::ST_HIT_CHK:
            state_in = (lk_type'(way_ff) == t_ff) ? salru_pkg::ST_DONE : salru_pkg::ST_UNLINK;
         salru_pkg::ST_UNLINK:    state_in = salru_pkg::ST_UNLINK_OWN;
         salru_pkg::ST_UNLINK_OWN:
            state_in = hit_ff ? salru_pkg::ST_APPEND_RD : salru_pkg::ST_DONE;
         salru_pkg::ST_APPEND_RD: state_in = salru_pkg::ST_APPEND;
         salru_pkg::ST_APPEND:    state_in = salru_pkg::ST_DONE;
         salru_pkg::ST_WALK_RD:   state_in = salru_pkg::ST_WALK;
         salru_pkg::ST_WALK: begin
            if (w_ff == salru_pkg::NIL || steps_ff == salru_pkg::STEP_W'(salru_pkg::WAYS))
               state_in = salru_pkg::ST_DONE;
            else if (kind_ff == salru_pkg::KIND_VICTIM && ivm_ff[w_ff[WW-1:0]])
               state_in = salru_pkg::ST_DONE;
            else if (kind_ff == salru_pkg::KIND_FLUSH && res_ff.fcount >= limit_ff)
               state_in = salru_pkg::ST_DONE;
            else
               state_in = salru_pkg::ST_WALK_RD;
         end
         salru_pkg::ST_DONE:
            if (!ob_busy) state_in = salru_pkg::ST_IDLE;
         default: state_in = salru_pkg::ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_in   = clr_ff;
      p_in = p_ff; n_in = n_ff; h_in = h_ff; t_in = t_ff;
      w_in = w_ff; steps_in = steps_ff; busy_in = busy_ff;
      res_in = res_ff; hit_in = hit_ff;
      set_raddr = set_ff;
      blk_raddr = blk_self;
      hw_en = 1'b0; tw_en = 1'b0; pw_en = 1'b0; nw_en = 1'b0;
      hw_a = set_ff; tw_a = set_ff; pw_a = blk_self; nw_a = blk_self;
      hw_d = salru_pkg::NIL; tw_d = salru_pkg::NIL;
      pw_d = salru_pkg::NIL; nw_d = salru_pkg::NIL;
      load = 1'b0;
      case (state_ff)
         salru_pkg::ST_CLEAR: begin
            hw_en = 1'b1; tw_en = 1'b1; pw_en = 1'b1; nw_en = 1'b1;
            hw_a = clr_ff[SW-1:0]; tw_a = clr_ff[SW-1:0];
            pw_a = clr_ff[BW-1:0]; nw_a = clr_ff[BW-1:0];
            clr_in = clr_ff + 1'b1;
         end
         salru_pkg::ST_IDLE: begin
            res_in = '0;
            hit_in = (req_kind == salru_pkg::KIND_HIT);
            steps_in = '0;
            busy_in = req_busy_mask;
         end
         salru_pkg::ST_RD_SET: ;
         salru_pkg::ST_RD_BLK: begin
            h_in = salru_pkg::clean_link(head_rd);
            t_in = salru_pkg::clean_link(tail_rd);
            p_in = salru_pkg::clean_link(prev_rd);
            n_in = salru_pkg::clean_link(next_rd);
            w_in = salru_pkg::clean_link(head_rd);
         end
         salru_pkg::ST_HIT_CHK: ;
         salru_pkg::ST_UNLINK: begin
            if (p_ff != salru_pkg::NIL || n_ff != salru_pkg::NIL) begin
               if (p_ff == salru_pkg::NIL) begin
                  hw_en = 1'b1; hw_d = n_ff;
               end else begin
                  nw_en = 1'b1; nw_a = {set_ff, p_ff[WW-1:0]}; nw_d = n_ff;
               end
               if (n_ff != salru_pkg::NIL) begin
                  pw_en = 1'b1; pw_a = {set_ff, n_ff[WW-1:0]}; pw_d = p_ff;
               end else begin
                  tw_en = 1'b1; tw_d = p_ff;
               end
            end else begin
               hw_en = 1'b1; tw_en = 1'b1;
            end
         end
         salru_pkg::ST_UNLINK_OWN: begin
            // drop the block's own links once its neighbours are rewired
            pw_en = 1'b1; nw_en = 1'b1;
         end
         salru_pkg::ST_APPEND_RD: begin
            nw_en = 1'b1;
         end
         salru_pkg::ST_APPEND: begin
            // head/tail freshly read when appending after an unlink
            if (kind_ff == salru_pkg::KIND_HIT) begin
               h_in = salru_pkg::clean_link(head_rd);
               t_in = salru_pkg::clean_link(tail_rd);
            end
            tw_en = 1'b1; tw_d = lk_type'(way_ff);
            pw_en = 1'b1;
            if (append_t != salru_pkg::NIL && append_h != salru_pkg::NIL) begin
               nw_en = 1'b1;
               nw_a = {set_ff, append_t[WW-1:0]}; nw_d = lk_type'(way_ff);
               pw_d = append_t;
            end else begin
               hw_en = 1'b1; hw_d = lk_type'(way_ff);
               pw_d = salru_pkg::NIL;
            end
         end
         salru_pkg::ST_WALK_RD: begin
            blk_raddr = {set_ff, w_ff[WW-1:0]};
         end
         salru_pkg::ST_WALK: begin
            if (w_ff != salru_pkg::NIL && steps_ff != salru_pkg::STEP_W'(salru_pkg::WAYS)) begin
               if (kind_ff == salru_pkg::KIND_VICTIM) begin
                  if (ivm_ff[w_ff[WW-1:0]]) begin
                     res_in.found = 1'b1;
                     res_in.index = {set_ff, w_ff[WW-1:0]};
                  end
               end else if (res_ff.fcount < limit_ff) begin
                  if (dm_ff[w_ff[WW-1:0]] && !busy_ff[w_ff[WW-1:0]]) begin
                     res_in.fmask[w_ff[WW-1:0]] = 1'b1;
                     busy_in[w_ff[WW-1:0]] = 1'b1;
                     res_in.fcount = res_ff.fcount + 1'b1;
                  end
               end
               w_in = salru_pkg::clean_link(next_rd);
               steps_in = steps_ff + 1'b1;
            end
         end
         salru_pkg::ST_DONE: load = !ob_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= salru_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      p_ff <= p_in; n_ff <= n_in; h_ff <= h_in; t_ff <= t_in;
      w_ff <= w_in; steps_ff <= steps_in; busy_ff <= busy_in;
      res_ff <= res_in; hit_ff <= hit_in;
      if (accept) begin
         kind_ff  <= req_kind;
         set_ff   <= (req_kind == salru_pkg::KIND_VICTIM || req_kind == salru_pkg::KIND_FLUSH)
                     ? req_set_index : req_block_index[BW-1:WW];
         way_ff   <= req_block_index[WW-1:0];
         ivm_ff   <= req_idle_valid_mask;
         dm_ff    <= req_dirty_mask;
         limit_ff <= req_flush_limit;
      end
   end

   salru_outbuf u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .data      (res_ff),
      .busy      (ob_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .q         (ob_q)
   );

   assign rsp_victim_found  = ob_q.found;
   assign rsp_victim_index  = ob_q.index;
   assign rsp_flush_mask    = ob_q.fmask;
   assign rsp_flushed_count = ob_q.fcount;

   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == salru_pkg::ST_CLEAR) |-> req_stall) else $error("request during clear");
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      load |=> (state_ff == salru_pkg::ST_IDLE)) else $error("load not followed by idle");
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == salru_pkg::ST_WALK) |-> (steps_ff <= salru_pkg::STEP_W'(salru_pkg::WAYS)))
      else $error("walk overran");
   a_count: assert property (@(posedge clock) disable iff (reset)
      load |-> ($countones(res_ff.fmask) == int'(res_ff.fcount)))
      else $error("flush count mismatch");
endmodule
